/* hw/rtl/dec_pkg.sv */
// ----------------------------------------------------------------------------
// dec_pkg
// Shared types and saturating helpers for the disc collision step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dec_pkg;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic        [11:0] r;
  } dec_disc_t;

  localparam int DiscW = $bits(dec_disc_t);

  // register indexes of the configuration port
  localparam logic [1:0] REG_BOUND_X = 2'd0;
  localparam logic [1:0] REG_BOUND_Y = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] res;
    if (v > 64'sd32767) begin
      res = 16'sd32767;
    end else if (v < -64'sd32768) begin
      res = -16'sd32768;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return sat16(-64'(v));
  endfunction

  // divide by 4096, truncating toward zero
  function automatic logic signed [47:0] shr12(input logic signed [59:0] v);
    logic signed [59:0] t;
    t = v[59] ? v + 60'sd4095 : v;
    return t[59:12];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dec_ram.sv */
// ----------------------------------------------------------------------------
// dec_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dec_ram #(
  parameter int WIDTH = 76,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/dec_div.sv */
// ----------------------------------------------------------------------------
// dec_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dec_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 34
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, q_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      q_q   <= {q_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

/* hw/rtl/disc_elastic_collision_step_unit.sv */
// ----------------------------------------------------------------------------
// disc_elastic_collision_step_unit
// Fixed-point 2-D elastic disc collisions in a walled arena.
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    op, disc_index, load_pos/vel, radius
// out       out  out_valid_o / out_ready_i  out_index, out_pos_x/y, last
// cfg       in   APB psel/penable/pready    bound_x, bound_y, disc_count
//
// A load writes one disc entry. A tick tests each pair of discs in turn. A
// touching pair is stepped back, makes three passes through the shared divider
// (or none when the response is skipped) and is moved forward again.
// Each disc then gets wall and move work, and any stall on the output channel
// holds the sequencer.
// Reset clears all discs (per-entry valid bits) and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module disc_elastic_collision_step_unit #(
  parameter int MAX_DISCS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [4:0]         disc_index_i,
  input  wire logic signed [15:0] load_pos_x_i,
  input  wire logic signed [15:0] load_pos_y_i,
  input  wire logic signed [15:0] load_vel_x_i,
  input  wire logic signed [15:0] load_vel_y_i,
  input  wire logic [11:0]        load_radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              out_index_o,
  output logic signed [15:0]      out_pos_x_o,
  output logic signed [15:0]      out_pos_y_o,
  output logic                    last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  import dec_pkg::*;

  localparam int IDX_W = $clog2(MAX_DISCS);
  localparam int CAP   = (MAX_DISCS < 32) ? MAX_DISCS : 32;
  localparam logic [5:0] CapN = 6'(CAP);
  localparam int NUM_W = 56;
  localparam int DEN_W = 34;

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_RDI  = 6'd1;
  localparam logic [5:0] S_RDJ  = 6'd2;
  localparam logic [5:0] S_LDJ  = 6'd3;
  localparam logic [5:0] S_TX   = 6'd4;
  localparam logic [5:0] S_TY   = 6'd5;
  localparam logic [5:0] S_TR   = 6'd6;
  localparam logic [5:0] S_TCMP = 6'd7;
  localparam logic [5:0] S_BACK = 6'd8;
  localparam logic [5:0] S_DX   = 6'd9;
  localparam logic [5:0] S_DY   = 6'd10;
  localparam logic [5:0] S_MA   = 6'd11;
  localparam logic [5:0] S_MB   = 6'd12;
  localparam logic [5:0] S_DOTX = 6'd13;
  localparam logic [5:0] S_DOTY = 6'd14;
  localparam logic [5:0] S_DOT  = 6'd15;
  localparam logic [5:0] S_CHK  = 6'd16;
  localparam logic [5:0] S_SDIV = 6'd17;
  localparam logic [5:0] S_WAM  = 6'd18;
  localparam logic [5:0] S_WAD  = 6'd19;
  localparam logic [5:0] S_WAW  = 6'd20;
  localparam logic [5:0] S_WBM  = 6'd21;
  localparam logic [5:0] S_WBD  = 6'd22;
  localparam logic [5:0] S_WBW  = 6'd23;
  localparam logic [5:0] S_VAX  = 6'd24;
  localparam logic [5:0] S_VAY  = 6'd25;
  localparam logic [5:0] S_VBX  = 6'd26;
  localparam logic [5:0] S_VBY  = 6'd27;
  localparam logic [5:0] S_VEND = 6'd28;
  localparam logic [5:0] S_ADV  = 6'd29;
  localparam logic [5:0] S_WRI  = 6'd30;
  localparam logic [5:0] S_WRJ  = 6'd31;
  localparam logic [5:0] S_NEXT = 6'd32;
  localparam logic [5:0] S_WRD  = 6'd33;
  localparam logic [5:0] S_WLD  = 6'd34;
  localparam logic [5:0] S_W1   = 6'd35;
  localparam logic [5:0] S_W2   = 6'd36;
  localparam logic [5:0] S_WMV  = 6'd37;
  localparam logic [5:0] S_WWR  = 6'd38;

  logic [5:0] state_q, state_d;

  // configuration
  logic [14:0] bound_x_q;
  logic [14:0] bound_y_q;
  logic [5:0]  count_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_x_q <= 15'd7282;
      bound_y_q <= 15'd4096;
      count_q   <= 6'd21;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BOUND_X: bound_x_q <= pwdata[14:0];
        REG_BOUND_Y: bound_y_q <= pwdata[14:0];
        REG_COUNT:   count_q   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BOUND_X: prdata = {17'd0, bound_x_q};
      REG_BOUND_Y: prdata = {17'd0, bound_y_q};
      REG_COUNT:   prdata = {26'd0, count_q};
      default:     prdata = '0;
    endcase
  end

  // counters and working discs
  logic [5:0] i_q, j_q, k_q, n_q;
  dec_disc_t  a_q, b_q;
  logic [5:0] n_cap;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign n_cap      = (count_q > CapN) ? CapN : count_q;

  // disc store
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  dec_disc_t            ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [DiscW-1:0]     ram_rdata;
  dec_disc_t            rd_disc;
  logic [MAX_DISCS-1:0] valid_q;
  logic                 rd_valid_q;
  logic [6:0]           load_idx;
  logic                 load_ok;

  assign load_idx = {2'b00, disc_index_i};
  assign load_ok  = load_idx < 7'(MAX_DISCS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_idx[IDX_W-1:0];
    ram_wdata = '{px: load_pos_x_i, py: load_pos_y_i, vx: load_vel_x_i,
                  vy: load_vel_y_i, r: load_radius_i};
    case (state_q)
      S_IDLE: ram_we = in_fire && !op_i && load_ok;
      S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[IDX_W-1:0];
        ram_wdata = a_q;
      end
      S_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IDX_W-1:0];
        ram_wdata = b_q;
      end
      S_WWR: begin
        ram_we    = out_free;
        ram_waddr = k_q[IDX_W-1:0];
        ram_wdata = a_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_RDJ:   ram_raddr = j_q[IDX_W-1:0];
      S_WRD:   ram_raddr = k_q[IDX_W-1:0];
      default: ram_raddr = i_q[IDX_W-1:0];
    endcase
  end

  dec_ram #(
    .WIDTH (DiscW),
    .DEPTH (MAX_DISCS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  assign rd_disc = rd_valid_q ? dec_disc_t'(ram_rdata) : '0;

  // shared multiplier
  logic signed [16:0] dx, dy, dvx, dvy;
  logic        [12:0] rs;
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] mul_q;

  assign dx  = 17'(b_q.px) - 17'(a_q.px);
  assign dy  = 17'(b_q.py) - 17'(a_q.py);
  assign dvx = 17'(a_q.vx) - 17'(b_q.vx);
  assign dvy = 17'(a_q.vy) - 17'(b_q.vy);
  assign rs  = 13'(a_q.r) + 13'(b_q.r);

  logic signed [33:0] s_q, wa_q, wb_q;
  logic        [23:0] ma_q, mb_q;
  logic        [24:0] msum_q;
  logic        [33:0] dd_q;
  logic signed [35:0] acc_q, dot_q;
  logic               neg_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TX, S_DX: begin
        mul_a = 34'(dx);
        mul_b = 26'(dx);
      end
      S_TY, S_DY: begin
        mul_a = 34'(dy);
        mul_b = 26'(dy);
      end
      S_TR: begin
        mul_a = 34'($signed({1'b0, rs}));
        mul_b = 26'($signed({1'b0, rs}));
      end
      S_MA: begin
        mul_a = 34'($signed({1'b0, a_q.r}));
        mul_b = 26'($signed({1'b0, a_q.r}));
      end
      S_MB: begin
        mul_a = 34'($signed({1'b0, b_q.r}));
        mul_b = 26'($signed({1'b0, b_q.r}));
      end
      S_DOTX: begin
        mul_a = 34'(dvx);
        mul_b = 26'(dx);
      end
      S_DOTY: begin
        mul_a = 34'(dvy);
        mul_b = 26'(dy);
      end
      S_WAM: begin
        mul_a = s_q;
        mul_b = 26'($signed({1'b0, mb_q}));
      end
      S_WBM: begin
        mul_a = s_q;
        mul_b = 26'($signed({1'b0, ma_q}));
      end
      S_VAX: begin
        mul_a = wa_q;
        mul_b = 26'(dx);
      end
      S_VAY: begin
        mul_a = wa_q;
        mul_b = 26'(dy);
      end
      S_VBX: begin
        mul_a = wb_q;
        mul_b = 26'(dx);
      end
      S_VBY: begin
        mul_a = wb_q;
        mul_b = 26'(dy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 60'(mul_a) * 60'(mul_b);
  end

  // shared divider
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  logic signed [35:0] dot_mag;
  logic signed [59:0] prod_mag;
  logic signed [33:0] quot_s;

  assign dot_mag  = dot_q[35] ? -dot_q : dot_q;
  assign prod_mag = mul_q[59] ? -mul_q : mul_q;
  assign quot_s   = neg_q ? -$signed({1'b0, div_quot[32:0]}) : $signed({1'b0, div_quot[32:0]});

  always_comb begin
    div_start = 1'b0;
    div_num   = prod_mag[NUM_W-1:0];
    div_den   = 34'(msum_q);
    case (state_q)
      S_CHK: begin
        div_start = (dd_q != '0) && (msum_q != '0);
        div_num   = NUM_W'({dot_mag[34:0], 13'd0});
        div_den   = dd_q;
      end
      S_WAD, S_WBD: div_start = 1'b1;
      default: ;
    endcase
  end

  dec_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // wall tests
  logic signed [19:0] wx1, wy1, wx2, wy2;
  logic signed [19:0] bx, by;

  assign bx  = 20'($signed({1'b0, bound_x_q}));
  assign by  = 20'($signed({1'b0, bound_y_q}));
  assign wx1 = 20'(a_q.px) + 20'($signed({1'b0, a_q.r})) + 20'(a_q.vx);
  assign wy1 = 20'(a_q.py) + 20'($signed({1'b0, a_q.r})) + 20'(a_q.vy);
  assign wx2 = 20'(a_q.px) - 20'($signed({1'b0, a_q.r})) + 20'(a_q.vx);
  assign wy2 = 20'(a_q.py) - 20'($signed({1'b0, a_q.r})) + 20'(a_q.vy);

  // sequencer
  logic [6:0] j_nx, i_nx2;
  assign j_nx  = {1'b0, j_q} + 7'd1;
  assign i_nx2 = {1'b0, i_q} + 7'd2;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && op_i) begin
          if (n_cap >= 6'd2) begin
            state_d = S_RDI;
          end else if (n_cap == 6'd1) begin
            state_d = S_WRD;
          end
        end
      end
      S_RDI:  state_d = S_RDJ;
      S_RDJ:  state_d = S_LDJ;
      S_LDJ:  state_d = S_TX;
      S_TX:   state_d = S_TY;
      S_TY:   state_d = S_TR;
      S_TR:   state_d = S_TCMP;
      S_TCMP: state_d = (acc_q <= 36'(mul_q)) ? S_BACK : S_NEXT;
      S_BACK: state_d = S_DX;
      S_DX:   state_d = S_DY;
      S_DY:   state_d = S_MA;
      S_MA:   state_d = S_MB;
      S_MB:   state_d = S_DOTX;
      S_DOTX: state_d = S_DOTY;
      S_DOTY: state_d = S_DOT;
      S_DOT:  state_d = S_CHK;
      S_CHK:  state_d = div_start ? S_SDIV : S_ADV;
      S_SDIV: state_d = div_done ? S_WAM : S_SDIV;
      S_WAM:  state_d = S_WAD;
      S_WAD:  state_d = S_WAW;
      S_WAW:  state_d = div_done ? S_WBM : S_WAW;
      S_WBM:  state_d = S_WBD;
      S_WBD:  state_d = S_WBW;
      S_WBW:  state_d = div_done ? S_VAX : S_WBW;
      S_VAX:  state_d = S_VAY;
      S_VAY:  state_d = S_VBX;
      S_VBX:  state_d = S_VBY;
      S_VBY:  state_d = S_VEND;
      S_VEND: state_d = S_ADV;
      S_ADV:  state_d = S_WRI;
      S_WRI:  state_d = S_WRJ;
      S_WRJ:  state_d = S_NEXT;
      S_NEXT: begin
        if (j_nx < {1'b0, n_q} || i_nx2 < {1'b0, n_q}) begin
          state_d = S_RDI;
        end else begin
          state_d = S_WRD;
        end
      end
      S_WRD:  state_d = S_WLD;
      S_WLD:  state_d = S_W1;
      S_W1:   state_d = S_W2;
      S_W2:   state_d = S_WMV;
      S_WMV:  state_d = S_WWR;
      S_WWR: begin
        if (out_free) begin
          state_d = (k_q + 6'd1 == n_q) ? S_IDLE : S_WRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      n_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_WWR && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && op_i) begin
            n_q <= n_cap;
            i_q <= 6'd0;
            j_q <= 6'd1;
            k_q <= 6'd0;
          end
        end
        S_NEXT: begin
          if (j_nx < {1'b0, n_q}) begin
            j_q <= j_nx[5:0];
          end else begin
            i_q <= i_q + 6'd1;
            j_q <= i_nx2[5:0];
          end
        end
        S_WWR: begin
          if (out_free) begin
            k_q <= k_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_RDJ: a_q <= rd_disc;
      S_LDJ: b_q <= rd_disc;
      S_WLD: a_q <= rd_disc;
      S_TY, S_DY, S_DOTY: acc_q <= 36'(mul_q);
      S_TR: acc_q <= acc_q + 36'(mul_q);
      S_BACK: begin
        a_q.px <= sat16(64'(a_q.px) - 64'(a_q.vx));
        a_q.py <= sat16(64'(a_q.py) - 64'(a_q.vy));
        b_q.px <= sat16(64'(b_q.px) - 64'(b_q.vx));
        b_q.py <= sat16(64'(b_q.py) - 64'(b_q.vy));
      end
      S_MA: dd_q <= 34'(acc_q + 36'(mul_q));
      S_MB: ma_q <= mul_q[23:0];
      S_DOTX: begin
        mb_q   <= mul_q[23:0];
        msum_q <= {1'b0, ma_q} + {1'b0, mul_q[23:0]};
      end
      S_DOT: dot_q <= acc_q + 36'(mul_q);
      S_CHK: neg_q <= dot_q[35];
      S_SDIV: if (div_done) s_q <= quot_s;
      S_WAD, S_WBD: neg_q <= mul_q[59];
      S_WAW: if (div_done) wa_q <= quot_s;
      S_WBW: if (div_done) wb_q <= quot_s;
      S_VAY:  a_q.vx <= sat16(64'(a_q.vx) - 64'(shr12(mul_q)));
      S_VBX:  a_q.vy <= sat16(64'(a_q.vy) - 64'(shr12(mul_q)));
      S_VBY:  b_q.vx <= sat16(64'(b_q.vx) + 64'(shr12(mul_q)));
      S_VEND: b_q.vy <= sat16(64'(b_q.vy) + 64'(shr12(mul_q)));
      S_ADV: begin
        a_q.px <= sat16(64'(a_q.px) + 64'(a_q.vx));
        a_q.py <= sat16(64'(a_q.py) + 64'(a_q.vy));
        b_q.px <= sat16(64'(b_q.px) + 64'(b_q.vx));
        b_q.py <= sat16(64'(b_q.py) + 64'(b_q.vy));
      end
      S_W1: begin
        if (wx1 >= bx) a_q.vx <= neg_sat(a_q.vx);
        if (wy1 >= by) a_q.vy <= neg_sat(a_q.vy);
      end
      S_W2: begin
        if (wx2 <= -bx) a_q.vx <= neg_sat(a_q.vx);
        if (wy2 <= -by) a_q.vy <= neg_sat(a_q.vy);
      end
      S_WMV: begin
        a_q.px <= sat16(64'(a_q.px) + 64'(a_q.vx));
        a_q.py <= sat16(64'(a_q.py) + 64'(a_q.vy));
      end
      S_WWR: begin
        if (out_free) begin
          out_index_o <= k_q[4:0];
          out_pos_x_o <= a_q.px;
          out_pos_y_o <= a_q.py;
          last_o      <= (k_q + 6'd1 == n_q);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* tb/disc_elastic_collision_step_checker.sv */
// ----------------------------------------------------------------------------
// disc_elastic_collision_step_checker
// Watches the input, output and register channels of the disc collision step
// unit. Keeps its own copy of the disc store and the registers, works out the
// positions that each tick reports and compares every result item with them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_elastic_collision_step_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               op_i,
  input  logic [4:0]         disc_index_i,
  input  logic signed [15:0] load_pos_x_i,
  input  logic signed [15:0] load_pos_y_i,
  input  logic signed [15:0] load_vel_x_i,
  input  logic signed [15:0] load_vel_y_i,
  input  logic [11:0]        load_radius_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [4:0]         out_index_i,
  input  logic signed [15:0] out_pos_x_i,
  input  logic signed [15:0] out_pos_y_i,
  input  logic               last_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 reports_seen_o
);

  import dec_pkg::*;

  localparam int NumDiscs = 32;

  typedef struct {
    logic [4:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } pos_report_t;

  dec_disc_t   discs [NumDiscs];
  logic [14:0] bnd_x;
  logic [14:0] bnd_y;
  logic [5:0]  count;
  pos_report_t report_q[$];

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic nudge(input int k, input longint sgn);
    discs[k].px = clamp16(longint'(discs[k].px) + sgn * longint'(discs[k].vx));
    discs[k].py = clamp16(longint'(discs[k].py) + sgn * longint'(discs[k].vy));
  endtask

  task automatic exchange_momentum(input int a, input int b);
    longint dx, dy, dd, ma, mb, msum, dot, s, wa, wb;
    dx = longint'(discs[b].px) - longint'(discs[a].px);
    dy = longint'(discs[b].py) - longint'(discs[a].py);
    dd = dx * dx + dy * dy;
    ma = longint'(discs[a].r) * longint'(discs[a].r);
    mb = longint'(discs[b].r) * longint'(discs[b].r);
    msum = ma + mb;
    if (dd == 0 || msum == 0) return;
    dot = (longint'(discs[a].vx) - longint'(discs[b].vx)) * dx
        + (longint'(discs[a].vy) - longint'(discs[b].vy)) * dy;
    s = (dot * 2 * 4096) / dd;
    wa = (s * mb) / msum;
    wb = (s * ma) / msum;
    discs[a].vx = clamp16(longint'(discs[a].vx) - (wa * dx) / 4096);
    discs[a].vy = clamp16(longint'(discs[a].vy) - (wa * dy) / 4096);
    discs[b].vx = clamp16(longint'(discs[b].vx) + (wb * dx) / 4096);
    discs[b].vy = clamp16(longint'(discs[b].vy) + (wb * dy) / 4096);
  endtask

  function automatic logic signed [15:0] reflect(input logic signed [15:0] p,
                                                 input logic [11:0] r,
                                                 input logic signed [15:0] v,
                                                 input logic [14:0] bound);
    logic signed [15:0] nv;
    longint lim;
    nv = v;
    lim = longint'(bound);
    if (longint'(p) + longint'(r) + longint'(nv) >= lim) nv = clamp16(-longint'(nv));
    if (longint'(p) - longint'(r) + longint'(nv) <= -lim) nv = clamp16(-longint'(nv));
    return nv;
  endfunction

  task automatic run_tick();
    int n;
    longint dx, dy, rs;
    pos_report_t rep;
    n = (count > NumDiscs) ? NumDiscs : int'(count);
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = longint'(discs[j].px) - longint'(discs[i].px);
        dy = longint'(discs[j].py) - longint'(discs[i].py);
        rs = longint'(discs[i].r) + longint'(discs[j].r);
        if (dx * dx + dy * dy <= rs * rs) begin
          nudge(i, -1);
          nudge(j, -1);
          exchange_momentum(i, j);
          nudge(i, 1);
          nudge(j, 1);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      discs[i].vx = reflect(discs[i].px, discs[i].r, discs[i].vx, bnd_x);
      discs[i].vy = reflect(discs[i].py, discs[i].r, discs[i].vy, bnd_y);
      nudge(i, 1);
      rep.idx = i[4:0];
      rep.x = discs[i].px;
      rep.y = discs[i].py;
      rep.last = (i == n - 1);
      report_q = {report_q, rep};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pos_report_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NumDiscs; k++) discs[k] = '0;
      bnd_x = 15'd7282;
      bnd_y = 15'd4096;
      count = 6'd21;
      report_q.delete();
      errors_o = 0;
      reports_seen_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_BOUND_X: bnd_x = pwdata_i[14:0];
          REG_BOUND_Y: bnd_y = pwdata_i[14:0];
          REG_COUNT:   count = pwdata_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i) begin
          run_tick();
        end else begin
          discs[disc_index_i] = '{load_pos_x_i, load_pos_y_i, load_vel_x_i,
                                  load_vel_y_i, load_radius_i};
        end
      end
      if (out_valid_i && out_ready_i) begin
        reports_seen_o++;
        if (report_q.size() == 0) begin
          errors_o++;
          $display("%0t unexpected item: idx %0d x %0d y %0d last %0d", $time,
                   out_index_i, out_pos_x_i, out_pos_y_i, last_i);
        end else begin
          want = report_q.pop_front();
          if (want.idx !== out_index_i || want.x !== out_pos_x_i ||
              want.y !== out_pos_y_i || want.last !== last_i) begin
            errors_o++;
            $display("%0t mismatch: expected idx %0d x %0d y %0d last %0d,",
                     $time, want.idx, want.x, want.y, want.last,
                     " got idx %0d x %0d y %0d last %0d",
                     out_index_i, out_pos_x_i, out_pos_y_i, last_i);
          end
        end
      end
    end
    pending_o = report_q.size();
  end

endmodule

/* tb/disc_elastic_collision_step_unit_tb.sv */
// ----------------------------------------------------------------------------
// disc_elastic_collision_step_unit_tb
// Drives loads and ticks into the disc collision step unit under several
// arena and disc count settings, with random gaps on both channels and one
// long output stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_elastic_collision_step_unit_tb;
  import dec_pkg::*;

  localparam int CycleLimit = 5000000;
  localparam int DrainCycles = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               op_i;
  logic [4:0]         disc_index_i;
  logic signed [15:0] load_pos_x_i;
  logic signed [15:0] load_pos_y_i;
  logic signed [15:0] load_vel_x_i;
  logic signed [15:0] load_vel_y_i;
  logic [11:0]        load_radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [4:0]         out_index_o;
  logic signed [15:0] out_pos_x_o;
  logic signed [15:0] out_pos_y_o;
  logic               last_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int errors;
  int pending;
  int reports_seen;
  int cycles = 0;
  int gap_mode;
  int cur_count;
  int cur_bx;
  int cur_by;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  disc_elastic_collision_step_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .disc_index_i,
    .load_pos_x_i, .load_pos_y_i, .load_vel_x_i, .load_vel_y_i, .load_radius_i,
    .out_valid_o, .out_ready_i, .out_index_o, .out_pos_x_o, .out_pos_y_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  disc_elastic_collision_step_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .disc_index_i,
    .load_pos_x_i, .load_pos_y_i, .load_vel_x_i, .load_vel_y_i, .load_radius_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_index_i(out_index_o),
    .out_pos_x_i(out_pos_x_o), .out_pos_y_i(out_pos_y_o), .last_i(last_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(pending), .reports_seen_o(reports_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int k;
    if (gap_mode == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic op, input logic [4:0] idx,
                           input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] vx, input logic [15:0] vy,
                           input logic [11:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    disc_index_i  <= idx;
    load_pos_x_i  <= px;
    load_pos_y_i  <= py;
    load_vel_x_i  <= vx;
    load_vel_y_i  <= vy;
    load_radius_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic tick();
    send_item(1'b1, 5'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 12'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int bx, input int by, input int n);
    settle();
    reg_write(REG_BOUND_X, bx);
    reg_write(REG_BOUND_Y, by);
    reg_write(REG_COUNT, n);
    cur_bx = bx;
    cur_by = by;
    cur_count = n;
  endtask

  function automatic logic [15:0] rand_coord(input int b);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * b) - b);
  endfunction

  function automatic logic [15:0] rand_vel();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 600)) - 300);
  endfunction

  task automatic rand_load();
    logic [4:0]  idx;
    logic [11:0] r;
    if ($urandom_range(0, 9) < 8 && cur_count > 0)
      idx = 5'($urandom_range(0, (cur_count > 32 ? 32 : cur_count) - 1));
    else
      idx = 5'($urandom);
    r = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 700));
    send_item(1'b0, idx, rand_coord(cur_bx), rand_coord(cur_by), rand_vel(),
              rand_vel(), r);
  endtask

  // output side: random ready, one long hold-off once traffic is under way
  initial begin
    int k;
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      if (!held && reports_seen >= 40) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end else if (k < 95) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(10, 50)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= 1'b0;
    disc_index_i  <= '0;
    load_pos_x_i  <= '0;
    load_pos_y_i  <= '0;
    load_vel_x_i  <= '0;
    load_vel_y_i  <= '0;
    load_radius_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    gap_mode      = 1;
    cur_bx        = 7282;
    cur_by        = 4096;
    cur_count     = 21;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all discs coincident at reset: every pair touches with zero distance
    tick();
    send_item(1'b0, 5'd0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 12'hfff);
    send_item(1'b0, 5'd1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 12'h000);
    send_item(1'b0, 5'd2, 16'd0, 16'd0, 16'd100, 16'd0, 12'd1000);
    send_item(1'b0, 5'd3, 16'd1500, 16'd0, -16'sd100, 16'd50, 12'd1000);
    send_item(1'b0, 5'd31, 16'd300, -16'sd200, 16'd7, -16'sd9, 12'd40);
    tick();
    tick();
    configure(0, 32767, 2);
    tick();
    configure(0, 32767, 4);
    tick();
    configure(7282, 4096, 1);
    tick();
    configure(7282, 4096, 0);
    tick();
    configure(32767, 0, 63);
    tick();
    configure(32767, 0, 32);
    tick();

    for (int ph = 0; ph < 5; ph++) begin
      configure($urandom_range(2000, 20000), $urandom_range(2000, 20000),
                $urandom_range(2, 8));
      gap_mode = (ph == 2) ? 0 : 1;
      for (int k = 0; k < cur_count; k++) rand_load();
      for (int k = 0; k < 24 - cur_count; k++) begin
        if ($urandom_range(0, 9) < 6) rand_load();
        else tick();
      end
      tick();
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dec_pkg.sv
hw/rtl/dec_ram.sv
hw/rtl/dec_div.sv
hw/rtl/disc_elastic_collision_step_unit.sv
tb/disc_elastic_collision_step_checker.sv
tb/disc_elastic_collision_step_unit_tb.sv
